[rtl/gpmk_pkg.sv]
// Package for the genotype pair match kernel: item and result types,
// work descriptors passed from front to back, state and code enums.
// No dependencies.
`default_nettype none
package gpmk_pkg;

	localparam int MAX_POSITIONS_DEF = 4096;
	localparam int MAX_ADDR_W        = 16;
	localparam int SYM_W             = 8;
	localparam int POS_W             = 12;
	localparam int COUNT_W           = 12;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [SYM_W-1:0]   SYM_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0]   SYM_EMPTY = 8'h00;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_TRAIN = 2'd1,
		OP_CMP   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		K_CLEAR = 2'd0,
		K_TRAIN = 2'd1,
		K_CMP   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_IDLE  = 2'd1,
		BK_EXEC  = 2'd2
	} bk_state_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [POS_W-1:0] position;
		logic [SYM_W-1:0] sym_a1;
		logic [SYM_W-1:0] sym_a2;
		logic [SYM_W-1:0] sym_b1;
		logic [SYM_W-1:0] sym_b2;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] kernel_value;
		logic               impossible_seen;
	} result_t;

	// One classified unit of work for the back end.
	typedef struct packed {
		kind_t                 kind;
		logic [MAX_ADDR_W-1:0] addr;
		logic                  in_range;
		logic [SYM_W-1:0]      sym;
		logic                  het_hit;
		logic                  hom_hit;
		logic                  last;
	} work_t;

	typedef struct packed {
		logic [SYM_W-1:0] first;
		logic [SYM_W-1:0] second;
	} entry_t;

endpackage
`default_nettype wire

[rtl/gpmk_front.sv]
// Front end: accepts items, drops those with no effect, and classifies
// compare pairs into work descriptors. Depends on gpmk_pkg.
`default_nettype none
module gpmk_front import gpmk_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  wire item_t item,
	input  wire        item_valid,
	output logic       item_ready,
	input  wire        init_done,
	input  wire        push_ready,
	output logic       push,
	output work_t      push_data
);

	logic [MAX_ADDR_W:0] pos_ext;
	logic                in_range;
	logic                het_a;
	logic                het_b;
	logic                keep;

	assign pos_ext  = (MAX_ADDR_W+1)'(item.position);
	assign in_range = pos_ext < (MAX_ADDR_W+1)'(MAX_POSITIONS);

	// Pair tests are order-free, so no sort is needed here.
	assign het_a = (item.sym_a1 != item.sym_a2) || (item.sym_a1 == SYM_ZERO)
		|| (item.sym_a2 == SYM_ZERO);
	assign het_b = (item.sym_b1 != item.sym_b2) || (item.sym_b1 == SYM_ZERO)
		|| (item.sym_b2 == SYM_ZERO);

	always_comb begin
		push_data          = '0;
		push_data.addr     = MAX_ADDR_W'(item.position);
		push_data.in_range = in_range;
		push_data.sym      = item.sym_a1;
		push_data.het_hit  = het_a && het_b;
		push_data.hom_hit  = !(het_a && het_b) && (item.sym_a1 == item.sym_a2)
			&& (item.sym_b1 == item.sym_b2) && (item.sym_a1 == item.sym_b1);
		push_data.last     = item.last;
		keep               = 1'b0;
		unique case (item.op)
			OP_CLEAR: begin
				push_data.kind = K_CLEAR;
				keep           = 1'b1;
			end
			OP_TRAIN: begin
				push_data.kind = K_TRAIN;
				keep           = in_range && (item.sym_a1 != SYM_ZERO);
			end
			OP_CMP: begin
				push_data.kind = K_CMP;
				keep           = 1'b1;
			end
			default: begin
				push_data.kind = K_CMP;
				keep           = 1'b0;
			end
		endcase
	end

	// Hold off until the power-up sweep is done and the queue has room.
	assign item_ready = init_done && push_ready;
	assign push       = item_valid && item_ready && keep;

endmodule
`default_nettype wire

[rtl/gpmk_queue.sv]
// Short work queue between front and back end.
// Depends on gpmk_pkg.
`default_nettype none
module gpmk_queue import gpmk_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	input  wire work_t push_data,
	output logic       push_ready,
	output logic       pop_valid,
	input  wire        pop,
	output work_t      pop_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	work_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/gpmk_back.sv]
// Back end: allele table memory with clearing sweep, train update,
// compare scoring, match counter, error flag and result register. Depends on gpmk_pkg.
`default_nettype none
module gpmk_back import gpmk_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          pop_valid,
	input  wire work_t   pop_data,
	output logic         pop,
	output logic         init_done,
	output logic         result_valid,
	input  wire          result_ready,
	output result_t      result
);

	localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

	entry_t             mem [MAX_POSITIONS];
	entry_t             rd_q;
	work_t              work_q;
	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [AW-1:0]      clr_idx_q;
	logic               clr_last;
	logic               init_done_q;
	logic [COUNT_W-1:0] count_q;
	logic               err_q;
	logic               out_valid_q;
	result_t            out_q;
	logic               out_busy;
	logic               exec_fire;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	entry_t             mem_wdata;
	entry_t             train_entry;
	logic               train_upd;
	logic [SYM_W-1:0]   lo;
	logic [SYM_W-1:0]   hi;
	logic               hit;
	logic               err_hit;
	logic [COUNT_W-1:0] count_next;
	logic               emit;

	assign clr_last = clr_idx_q == AW'(MAX_POSITIONS - 1);
	assign out_busy = out_valid_q && !result_ready;

	// Train: first new symbol fills the first slot, first differing one the second.
	always_comb begin
		train_entry = rd_q;
		train_upd   = 1'b0;
		if (rd_q.first == SYM_EMPTY) begin
			train_entry.first = work_q.sym;
			train_upd         = 1'b1;
		end else if ((rd_q.second == SYM_EMPTY) && (work_q.sym != rd_q.first)) begin
			train_entry.second = work_q.sym;
			train_upd          = 1'b1;
		end
	end

	// Compare: empty slots and out-of-range positions read as '0'.
	assign lo = (!work_q.in_range || rd_q.first == SYM_EMPTY) ? SYM_ZERO : rd_q.first;
	assign hi = (!work_q.in_range || rd_q.second == SYM_EMPTY) ? SYM_ZERO : rd_q.second;
	assign hit        = work_q.het_hit || work_q.hom_hit;
	assign err_hit    = work_q.hom_hit && (work_q.sym != lo) && (work_q.sym != hi);
	assign count_next = (hit && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (pop_valid) begin
					state_d = (pop_data.kind == K_CLEAR) ? BK_CLEAR : BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (exec_fire) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		exec_fire = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_idx_q;
		mem_wdata = '0;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
			end
			BK_IDLE: begin
				pop = pop_valid;
			end
			BK_EXEC: begin
				exec_fire = !((work_q.kind == K_CMP) && work_q.last && out_busy);
				if (work_q.kind == K_TRAIN) begin
					mem_we    = exec_fire && train_upd;
					mem_waddr = work_q.addr[AW-1:0];
					mem_wdata = train_entry;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign emit = exec_fire && (work_q.kind == K_CMP) && work_q.last;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rd_q   <= mem[pop_data.addr[AW-1:0]];
			work_q <= pop_data;
		end
		if (emit) begin
			out_q.kernel_value    <= count_next;
			out_q.impossible_seen <= err_q || err_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_idx_q   <= '0;
			init_done_q <= 1'b0;
			count_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_idx_q <= clr_last ? '0 : clr_idx_q + 1'b1;
				if (clr_last) begin
					init_done_q <= 1'b1;
				end
			end
			if (exec_fire && work_q.kind == K_CMP) begin
				if (work_q.last) begin
					count_q <= '0;
					err_q   <= 1'b0;
				end else begin
					count_q <= count_next;
					err_q   <= err_q || err_hit;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign init_done    = init_done_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

[rtl/genotype_pair_match_kernel_top.sv]
// Top level of the genotype pair match kernel: front end, work queue, back end.
// Depends on gpmk_pkg, gpmk_front, gpmk_queue and gpmk_back.
//
// The block learns up to two alleles per string position from train items
// (op 1) and scores genotype pairs from two strings against each other on
// compare items (op 2); the compare item with last set returns the match
// count and the sticky impossible-homozygote flag, then clears both. Op 0
// wipes the allele tables. The front end takes one item per cycle, while
// the queue has room, into a two-entry queue; items with no effect (unused
// op code, train with '0' or a position beyond the table) are dropped
// there. The back end handles each train or compare item with a
// read-modify-write of the single-port allele table: it reads the entry as
// it takes the item from the queue, then updates it or scores the pair. A
// clear item is taken from the queue and then holds the back end as it
// clears one table entry per cycle, while the front keeps filling the
// queue. After reset the same sweep runs first, and item_ready stays low
// until it has finished. A result waits in an output register, so the back
// end only stalls when a second result is ready before the first one was
// taken.
`default_nettype none
module genotype_pair_match_kernel_top import gpmk_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire          result_ready,
	output result_t      result
);

	logic  init_done;
	logic  push;
	logic  push_ready;
	work_t push_data;
	logic  pop_valid;
	logic  pop;
	work_t pop_data;

	// Accept and classify; drop items that change nothing.
	gpmk_front #(
		.MAX_POSITIONS(MAX_POSITIONS)
	) u_front (
		.item      (item),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.init_done (init_done),
		.push_ready(push_ready),
		.push      (push),
		.push_data (push_data)
	);

	// Decouple the front, one item per cycle while the queue has room, from the back end's read-modify-write.
	gpmk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	// Table access, scoring and result delivery.
	gpmk_back #(
		.MAX_POSITIONS(MAX_POSITIONS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_data    (pop_data),
		.pop         (pop),
		.init_done   (init_done),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// No item may enter before the power-up sweep has finished.
	a_no_accept_before_init: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> init_done)
		else $error("item accepted before table sweep finished");

	// The front never pushes into a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_ready)
		else $error("push into full work queue");

	// A flagged homozygote is always a counted match.
	a_flag_implies_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.impossible_seen) |-> (result.kernel_value != '0))
		else $error("impossible flag set with zero match count");

endmodule
`default_nettype wire
